/* hw/rtl/rm2q_pkg.sv */
// Shared types and constants for the rotation matrix to quaternion block.
`default_nettype none

package rm2q_pkg;

    localparam int unsigned FRAC_BITS = 14;
    localparam int unsigned IN_W      = 16;
    localparam int unsigned OUT_W     = 16;
    localparam int unsigned MAG_W     = 15;

    localparam int unsigned ONE       = 1 << FRAC_BITS;
    localparam int unsigned MAG_CAP   = (ONE < 32767) ? ONE : 32767;

    // Largest positive signed diagonal sum is three times the input magnitude.
    localparam int unsigned T_W       = $clog2(3 * (1 << (IN_W - 1)) + ONE + 1);
    localparam int unsigned TS_W      = T_W + 2;
    localparam int unsigned RAD_W     = T_W + FRAC_BITS - 2;
    localparam int unsigned SQ_W      = (RAD_W + 1) / 2;
    localparam int unsigned REM_W     = SQ_W + 2;
    localparam int unsigned DPS       = 3;
    localparam int unsigned NSQ       = (SQ_W + DPS - 1) / DPS;

    localparam int unsigned NLANE     = 4;
    localparam int unsigned LANE_X    = 0;
    localparam int unsigned LANE_Y    = 1;
    localparam int unsigned LANE_Z    = 2;
    localparam int unsigned LANE_W    = 3;

    typedef struct packed {
        logic signed [IN_W-1:0] m00;
        logic signed [IN_W-1:0] m01;
        logic signed [IN_W-1:0] m02;
        logic signed [IN_W-1:0] m10;
        logic signed [IN_W-1:0] m11;
        logic signed [IN_W-1:0] m12;
        logic signed [IN_W-1:0] m20;
        logic signed [IN_W-1:0] m21;
        logic signed [IN_W-1:0] m22;
    } rm2q_in_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] quat_x;
        logic signed [OUT_W-1:0] quat_y;
        logic signed [OUT_W-1:0] quat_z;
        logic        [MAG_W-1:0] quat_w;
    } rm2q_out_t;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [SQ_W-1:0]   root;
        logic [2*SQ_W-1:0] rad;
    } rm2q_root_t;

    typedef rm2q_root_t [NLANE-1:0] rm2q_lanes_t;

    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic neg_z;
    } rm2q_sign_t;

endpackage

`default_nettype wire

/* hw/rtl/rm2q_root_pipe.sv */
// Pipelined integer square root over four lanes, a few digits per stage.
`default_nettype none

module rm2q_root_pipe (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire rm2q_pkg::rm2q_lanes_t in_lanes,
    input  wire rm2q_pkg::rm2q_sign_t  in_sign,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output rm2q_pkg::rm2q_lanes_t     out_lanes,
    output rm2q_pkg::rm2q_sign_t      out_sign
);
    import rm2q_pkg::*;

    function automatic int unsigned stage_digits(input int unsigned k);
        int unsigned left;
        left = SQ_W - k * DPS;
        return (left < DPS) ? left : DPS;
    endfunction

    function automatic rm2q_root_t root_digits(input rm2q_root_t cur, input int unsigned nd);
        rm2q_root_t       r;
        logic [REM_W+1:0] wide;
        logic [REM_W+1:0] trial;
        r = cur;
        for (int j = 0; j < DPS; j++) begin
            if (j < nd) begin
                wide  = {r.rem, r.rad[2*SQ_W-1 -: 2]};
                trial = (REM_W + 2)'({r.root, 2'b01});
                r.rad = r.rad << 2;
                if (wide >= trial) begin
                    wide   = wide - trial;
                    r.root = {r.root[SQ_W-2:0], 1'b1};
                end else begin
                    r.root = {r.root[SQ_W-2:0], 1'b0};
                end
                r.rem = wide[REM_W-1:0];
            end
        end
        return r;
    endfunction

    logic        v_reg    [NSQ];
    rm2q_lanes_t st_reg   [NSQ];
    rm2q_sign_t  sign_reg [NSQ];
    rm2q_lanes_t st_next  [NSQ];
    logic        rdy      [NSQ+1];

    always_comb begin
        rdy[NSQ] = out_ready;
        for (int k = NSQ - 1; k >= 0; k--) begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end

    always_comb begin
        for (int l = 0; l < NLANE; l++) begin
            st_next[0][l] = root_digits(in_lanes[l], stage_digits(0));
        end
        for (int k = 1; k < NSQ; k++) begin
            for (int l = 0; l < NLANE; l++) begin
                st_next[k][l] = root_digits(st_reg[k-1][l], stage_digits(k));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NSQ; k++) begin
                v_reg[k] <= 1'b0;
            end
        end else begin
            if (rdy[0]) begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < NSQ; k++) begin
                if (rdy[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            st_reg[0]   <= st_next[0];
            sign_reg[0] <= in_sign;
        end
        for (int k = 1; k < NSQ; k++) begin
            if (rdy[k]) begin
                st_reg[k]   <= st_next[k];
                sign_reg[k] <= sign_reg[k-1];
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[NSQ-1];
    assign out_lanes = st_reg[NSQ-1];
    assign out_sign  = sign_reg[NSQ-1];

    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[NSQ-1] |-> (REM_W + 1)'(st_reg[NSQ-1][LANE_W].rem)
                         <= (REM_W + 1)'({st_reg[NSQ-1][LANE_W].root, 1'b0}))
        else $error("root remainder exceeds twice the root");

    a_last_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[NSQ-1] && !out_ready |=> v_reg[NSQ-1] && $stable(st_reg[NSQ-1]))
        else $error("stalled root stage lost its item");

endmodule

`default_nettype wire

/* hw/rtl/rotation_matrix_to_quaternion.sv */
// Top level: rotation matrix in, unit quaternion out, pipelined at one item per cycle while m_ready allows.
//
//   Channel   Ports                      Item
//   input     s_valid s_ready s_data     nine matrix elements, signed Q1.14
//   output    m_valid m_ready m_data     quat_x quat_y quat_z signed, quat_w unsigned
//
// One item is taken every cycle unless m_ready holds the pipeline; an item passes the input
// register, NSQ square root stages of three digits each, and the output register.
// Reset clears every valid bit, so the pipeline comes up empty.
// While m_ready is low the result is held and earlier stages keep filling empty slots.
`default_nettype none

module rotation_matrix_to_quaternion (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire rm2q_pkg::rm2q_in_t s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output rm2q_pkg::rm2q_out_t     m_data
);
    import rm2q_pkg::*;

    localparam logic signed [OUT_W-1:0] CAP_S = OUT_W'(MAG_CAP);

    function automatic rm2q_root_t start_lane(input logic signed [TS_W-1:0] s);
        logic signed [TS_W-1:0] t;
        logic [T_W-1:0]         tu;
        rm2q_root_t             r;
        t  = s + TS_W'(ONE);
        tu = t[TS_W-1] ? '0 : t[T_W-1:0];
        r.rem  = '0;
        r.root = '0;
        r.rad  = (2 * SQ_W)'(tu) << (FRAC_BITS - 2);
        return r;
    endfunction

    function automatic logic [MAG_W-1:0] cap_mag(input logic [SQ_W-1:0] root);
        return (root > SQ_W'(MAG_CAP)) ? MAG_W'(MAG_CAP) : MAG_W'(root);
    endfunction

    function automatic logic [OUT_W-1:0] apply_sign(input logic [MAG_W-1:0] mag,
                                                    input logic neg);
        logic [OUT_W-1:0] v;
        v = OUT_W'(mag);
        return neg ? OUT_W'(-v) : v;
    endfunction

    logic signed [TS_W-1:0] a00, a11, a22;
    rm2q_lanes_t            a_lanes_next;
    rm2q_sign_t             a_sign_next;

    logic        a_v_reg;
    rm2q_lanes_t a_lanes_reg;
    rm2q_sign_t  a_sign_reg;
    logic        pipe_in_ready;

    logic        pipe_valid;
    logic        pipe_ready;
    rm2q_lanes_t pipe_lanes;
    rm2q_sign_t  pipe_sign;

    logic        m_valid_reg;
    rm2q_out_t   m_data_reg;
    rm2q_out_t   m_data_next;

    always_comb begin
        a00 = TS_W'(s_data.m00);
        a11 = TS_W'(s_data.m11);
        a22 = TS_W'(s_data.m22);
        a_lanes_next[LANE_X] = start_lane(a00 - a11 - a22);
        a_lanes_next[LANE_Y] = start_lane(a11 - a00 - a22);
        a_lanes_next[LANE_Z] = start_lane(a22 - a00 - a11);
        a_lanes_next[LANE_W] = start_lane(a00 + a11 + a22);
        a_sign_next.neg_x = s_data.m12 < s_data.m21;
        a_sign_next.neg_y = s_data.m20 < s_data.m02;
        a_sign_next.neg_z = s_data.m01 < s_data.m10;
    end

    assign s_ready = !a_v_reg || pipe_in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg <= 1'b0;
        end else if (s_ready) begin
            a_v_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready) begin
            a_lanes_reg <= a_lanes_next;
            a_sign_reg  <= a_sign_next;
        end
    end

    rm2q_root_pipe u_root (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (a_v_reg),
        .in_ready  (pipe_in_ready),
        .in_lanes  (a_lanes_reg),
        .in_sign   (a_sign_reg),
        .out_valid (pipe_valid),
        .out_ready (pipe_ready),
        .out_lanes (pipe_lanes),
        .out_sign  (pipe_sign)
    );

    assign pipe_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_data_next.quat_x = apply_sign(cap_mag(pipe_lanes[LANE_X].root), pipe_sign.neg_x);
        m_data_next.quat_y = apply_sign(cap_mag(pipe_lanes[LANE_Y].root), pipe_sign.neg_y);
        m_data_next.quat_z = apply_sign(cap_mag(pipe_lanes[LANE_Z].root), pipe_sign.neg_z);
        m_data_next.quat_w = cap_mag(pipe_lanes[LANE_W].root);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pipe_ready) begin
            m_valid_reg <= pipe_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_ready && pipe_valid) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_w_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.quat_w <= MAG_W'(MAG_CAP))
        else $error("scalar part above one");

    a_x_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.quat_x <= CAP_S) && (m_data.quat_x >= -CAP_S))
        else $error("x component outside unit range");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled while the output stage is empty");

endmodule

`default_nettype wire

/* dv/quat_checker.sv */
// Checker for the matrix to quaternion block: predicts each result and compares it.
module quat_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  rm2q_pkg::rm2q_in_t  s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  rm2q_pkg::rm2q_out_t m_data,
    output int                  n_errors,
    output int                  n_checked,
    output int                  n_pending
);
    import rm2q_pkg::*;

    rm2q_out_t expected_quats[$];

    function automatic logic [OUT_W-1:0] lane_magnitude(longint diag);
        longint          t;
        longint unsigned rad;
        longint unsigned root;
        longint unsigned trial;
        t = diag + longint'(ONE);
        if (t < 0) begin
            t = 0;
        end
        rad = (longint'(t) << FRAC_BITS) >> 2;
        root = 0;
        for (int b = 24; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= rad) begin
                root = trial;
            end
        end
        if (root > longint'(MAG_CAP)) begin
            root = MAG_CAP;
        end
        return root[OUT_W-1:0];
    endfunction

    function automatic rm2q_out_t predict_quaternion(rm2q_in_t m);
        longint           e00;
        longint           e11;
        longint           e22;
        int               dx;
        int               dy;
        int               dz;
        logic [OUT_W-1:0] mx;
        logic [OUT_W-1:0] my;
        logic [OUT_W-1:0] mz;
        logic [OUT_W-1:0] mw;
        rm2q_out_t        q;
        e00 = longint'($signed(m.m00));
        e11 = longint'($signed(m.m11));
        e22 = longint'($signed(m.m22));
        mx = lane_magnitude(e00 - e11 - e22);
        my = lane_magnitude(-e00 + e11 - e22);
        mz = lane_magnitude(-e00 - e11 + e22);
        mw = lane_magnitude(e00 + e11 + e22);
        dx = int'($signed(m.m12)) - int'($signed(m.m21));
        dy = int'($signed(m.m20)) - int'($signed(m.m02));
        dz = int'($signed(m.m01)) - int'($signed(m.m10));
        q.quat_x = (dx < 0) ? -mx : mx;
        q.quat_y = (dy < 0) ? -my : my;
        q.quat_z = (dz < 0) ? -mz : mz;
        q.quat_w = mw[MAG_W-1:0];
        return q;
    endfunction

    always @(posedge aclk) begin : monitor
        rm2q_out_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_quats.size() == 0) begin
                    $error("Unexpected quaternion %h with no matrix outstanding.", m_data);
                    n_errors++;
                end else begin
                    want = expected_quats.pop_front();
                    n_checked++;
                    if (m_data.quat_x !== want.quat_x) begin
                        $error("quat_x: expected %0d, got %0d",
                               $signed(want.quat_x), $signed(m_data.quat_x));
                        n_errors++;
                    end
                    if (m_data.quat_y !== want.quat_y) begin
                        $error("quat_y: expected %0d, got %0d",
                               $signed(want.quat_y), $signed(m_data.quat_y));
                        n_errors++;
                    end
                    if (m_data.quat_z !== want.quat_z) begin
                        $error("quat_z: expected %0d, got %0d",
                               $signed(want.quat_z), $signed(m_data.quat_z));
                        n_errors++;
                    end
                    if (m_data.quat_w !== want.quat_w) begin
                        $error("quat_w: expected %0d, got %0d", want.quat_w, m_data.quat_w);
                        n_errors++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                expected_quats.push_back(predict_quaternion(s_data));
            end
            n_pending = expected_quats.size();
        end
    end

endmodule

/* dv/rotation_matrix_to_quaternion_test.sv */
// Testbench top: drives matrices into the quaternion block and gives the verdict.
module rotation_matrix_to_quaternion_test;
    import rm2q_pkg::*;

    localparam int N_ITEMS    = 1150;
    localparam int CALM_ITEMS = 150;
    localparam int HOLD_AT    = 300;
    localparam int HOLD_LEN   = 400;
    localparam int STALL_MAX  = 3000;
    localparam int DRAIN      = 20;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    rm2q_in_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    rm2q_out_t m_data;

    int n_errors;
    int n_checked;
    int n_pending;
    int sent_count     = 0;
    int directed_count = 0;
    int quiet_cycles   = 0;
    bit calm           = 1'b0;

    always #5 aclk = ~aclk;

    rotation_matrix_to_quaternion dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    quat_checker checker_i (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .n_errors  (n_errors),
        .n_checked (n_checked),
        .n_pending (n_pending)
    );

    function automatic rm2q_in_t mat9(int a00, int a01, int a02, int a10, int a11,
                                      int a12, int a20, int a21, int a22);
        rm2q_in_t m;
        m.m00 = a00[IN_W-1:0];
        m.m01 = a01[IN_W-1:0];
        m.m02 = a02[IN_W-1:0];
        m.m10 = a10[IN_W-1:0];
        m.m11 = a11[IN_W-1:0];
        m.m12 = a12[IN_W-1:0];
        m.m20 = a20[IN_W-1:0];
        m.m21 = a21[IN_W-1:0];
        m.m22 = a22[IN_W-1:0];
        return m;
    endfunction

    function automatic int to_q14(real v);
        int r;
        r = $rtoi(v * real'(ONE) + ((v >= 0.0) ? 0.5 : -0.5));
        if (r > 32767) begin
            r = 32767;
        end else if (r < -32768) begin
            r = -32768;
        end
        return r;
    endfunction

    function automatic real unit_rand();
        return real'(int'($urandom_range(0, 20000)) - 10000) / 10000.0;
    endfunction

    function automatic rm2q_in_t random_rotation();
        real x;
        real y;
        real z;
        real w;
        real n;
        x = unit_rand();
        y = unit_rand();
        z = unit_rand();
        w = unit_rand();
        n = $sqrt(x * x + y * y + z * z + w * w);
        if (n < 1.0e-3) begin
            return mat9(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE);
        end
        x = x / n;
        y = y / n;
        z = z / n;
        w = w / n;
        return mat9(to_q14(1.0 - 2.0 * (y * y + z * z)), to_q14(2.0 * (x * y - z * w)),
                    to_q14(2.0 * (x * z + y * w)), to_q14(2.0 * (x * y + z * w)),
                    to_q14(1.0 - 2.0 * (x * x + z * z)), to_q14(2.0 * (y * z - x * w)),
                    to_q14(2.0 * (x * z - y * w)), to_q14(2.0 * (y * z + x * w)),
                    to_q14(1.0 - 2.0 * (x * x + y * y)));
    endfunction

    function automatic int corner_value();
        case ($urandom_range(0, 7))
            0: return -32768;
            1: return 32767;
            2: return -int'(ONE);
            3: return int'(ONE);
            4: return 0;
            5: return 1;
            6: return -1;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    function automatic rm2q_in_t random_matrix();
        rm2q_in_t m;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: m = random_rotation();
            5, 6, 7: begin
                m = mat9(corner_value(), corner_value(), corner_value(), corner_value(),
                         corner_value(), corner_value(), corner_value(), corner_value(),
                         corner_value());
            end
            default: m = rm2q_in_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
        endcase
        return m;
    endfunction

    task automatic send_matrix(rm2q_in_t m);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 16);
        end
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= m;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        sent_count++;
        calm = (sent_count >= N_ITEMS - CALM_ITEMS);
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_matrix(mat9(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE));
        send_matrix(mat9(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_matrix(mat9(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
        send_matrix(mat9(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                         -32768));
        send_matrix(mat9(ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE));
        send_matrix(mat9(-ONE, 0, 100, 0, ONE, 0, -100, 0, -ONE));
        send_matrix(mat9(-ONE, -5, 0, 5, -ONE, 0, 0, 0, ONE));
        send_matrix(mat9(ONE, 0, 0, 0, -ONE, -1, 0, 0, -ONE));
        send_matrix(mat9(32767, 0, 0, 0, -32768, 0, 0, 0, -32768));
        send_matrix(mat9(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768));
        send_matrix(mat9(0, 32767, 32767, 32767, 0, 32767, -32768, -32768, 0));
        send_matrix(mat9(0, -32768, -32768, 32767, 0, -32768, 32767, 32767, 0));
        send_matrix(mat9(0, -ONE, 0, ONE, 0, 0, 0, 0, ONE));
        send_matrix(mat9(-1, 0, 0, 0, 0, 0, 0, 0, 0));
        send_matrix(mat9(-ONE, 0, 0, 0, 0, 0, 0, 0, 0));
        send_matrix(mat9(-ONE - 1, 0, 0, 0, 0, 0, 0, 0, 0));
        send_matrix(mat9(16'h5555, 16'h5555, 16'h5555, 16'h5555, 16'h5555, 16'h5555,
                         16'h5555, 16'h5555, 16'h5555));
        send_matrix(mat9(16'hAAAA, 16'hAAAA, 16'hAAAA, 16'hAAAA, 16'hAAAA, 16'hAAAA,
                         16'hAAAA, 16'hAAAA, 16'hAAAA));
        send_matrix(mat9(1, 0, 0, 0, 1, 0, 0, 0, 1));
        send_matrix(mat9(-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE));
        directed_count = sent_count;

        while (sent_count < N_ITEMS) begin
            send_matrix(random_matrix());
        end
        s_valid <= 1'b0;

        wait (n_pending == 0);
        repeat (DRAIN) @(posedge aclk);

        $display("Sent %0d matrices (%0d directed corners, the rest random rotations,",
                 sent_count, directed_count);
        $display("corner mixes and raw words) and checked %0d quaternions.", n_checked);
        if (n_errors == 0 && n_pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin : receiver
        bit held;
        held = 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (calm) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else if (!held && sent_count >= HOLD_AT) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge aclk);
            end else begin
                m_ready <= ($urandom_range(0, 2) != 0);
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_MAX) begin
            $display("Run stalled with %0d quaternions outstanding.", n_pending);
            $display("TB_ERROR");
            $finish;
        end
    end

endmodule

/* rotation_matrix_to_quaternion.f */
hw/rtl/rm2q_pkg.sv
hw/rtl/rm2q_root_pipe.sv
hw/rtl/rotation_matrix_to_quaternion.sv
dv/quat_checker.sv
dv/rotation_matrix_to_quaternion_test.sv
